// File: src/ffba_pkg.sv
// ffba_pkg: shared types, codes and sizes for the first-fit block allocator
// no dependencies
`default_nettype none
package ffba_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int ADDR_BITS  = 16;
    localparam int FREE_DEPTH = MAX_BLOCKS + 1;
    localparam int FIDX_W     = $clog2(FREE_DEPTH + 1);
    localparam int UIDX_W     = $clog2(MAX_BLOCKS);
    localparam logic [15:0] MEM_SIZE_RESET = 16'd1024;

    localparam logic       MODE_CLAIM   = 1'b0;
    localparam logic       MODE_RELEASE = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFIT    = 3'd1;
    localparam logic [2:0] ST_NOTALLOC = 3'd2;
    localparam logic [2:0] ST_ZERO     = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic        mode;
        logic [15:0] req_size;
        logic [15:0] req_addr;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] block_addr;
        logic [15:0] block_size;
    } out_item_t;

    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] len;
    } cell_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_CLEAR
    } cell_cmd_t;

endpackage
`default_nettype wire

// File: src/first_fit_block_allocator_unit.sv
// first_fit_block_allocator_unit: first-fit allocator with free-block coalescing
// depends on ffba_pkg and ffba_cell (rows of free and used table cells)
//
//  channel   direction  handshake           payload
//  in        into       in_valid/in_stall   in_item  (mode, req_size, req_addr)
//  out       out of     out_valid/out_stall out_item (status, block_addr, block_size)
//  cfg       into       cfg_wr_en           cfg_wr_data (mem_size)
//
// a granted claim runs S_FIND, S_CLAIM_UPD, S_DONE; a granted release S_LOOK, S_FPOS,
// S_MERGE, S_DONE; zero-size, table-full, failed search and lookup jump to S_DONE
// after reset or a mem_size write, the tables are rebuilt before items are taken
// a result waits in the output register while out_stall is high; the next item is then
// taken, and its result waits until the register frees
`default_nettype none
module first_fit_block_allocator_unit
    import ffba_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_item,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_item,
    input  wire logic     cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_CLAIM_UPD,
        S_LOOK,
        S_FPOS,
        S_MERGE,
        S_DONE
    } state_t;

    state_t          state_reg;
    logic            init_pend_reg;
    logic [15:0]     mem_size_reg;
    in_item_t        item_reg;
    out_item_t       res_reg;
    out_item_t       out_reg;
    logic            out_valid_reg;
    logic [FIDX_W-1:0] fidx_reg;
    logic [FIDX_W-1:0] fpos_reg;
    logic [15:0]     a_reg;
    logic [15:0]     len_reg;

    cell_t     fcell [FREE_DEPTH];
    cell_t     ucell [MAX_BLOCKS];
    cell_cmd_t fcmd  [FREE_DEPTH];
    cell_cmd_t ucmd  [MAX_BLOCKS];
    cell_t     fload;
    cell_t     uload;
    logic [FREE_DEPTH-1:0] fv_vec;
    logic [MAX_BLOCKS-1:0] uv_vec;

    genvar g;
    generate
        for (g = 0; g < FREE_DEPTH; g++)
        begin : g_free
            cell_t pv;
            cell_t nx;
            if (g == 0)
            begin : g_first
                assign pv = '0;
            end
            else
            begin : g_mid
                assign pv = fcell[g-1];
            end
            if (g == FREE_DEPTH - 1)
            begin : g_last
                assign nx = '0;
            end
            else
            begin : g_body
                assign nx = fcell[g+1];
            end
            ffba_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .cmd    (fcmd[g]),
                .load_d (fload),
                .prev_d (pv),
                .next_d (nx),
                .cur    (fcell[g])
            );
            assign fv_vec[g] = fcell[g].valid;
        end
        for (g = 0; g < MAX_BLOCKS; g++)
        begin : g_used
            cell_t pv;
            cell_t nx;
            if (g == 0)
            begin : g_first
                assign pv = '0;
            end
            else
            begin : g_mid
                assign pv = ucell[g-1];
            end
            if (g == MAX_BLOCKS - 1)
            begin : g_last
                assign nx = '0;
            end
            else
            begin : g_body
                assign nx = ucell[g+1];
            end
            ffba_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .cmd    (ucmd[g]),
                .load_d (uload),
                .prev_d (pv),
                .next_d (nx),
                .cur    (ucell[g])
            );
            assign uv_vec[g] = ucell[g].valid;
        end
    endgenerate

    // searches across the rows
    logic              fit_found;
    logic [FIDX_W-1:0] fit_idx;
    logic              rel_found;
    logic [UIDX_W-1:0] rel_idx;
    logic [UIDX_W-1:0] upos;
    logic [FIDX_W-1:0] fpos;
    cell_t             f_at_pos;
    cell_t             f_before_pos;
    cell_t             f_at_idx;
    cell_t             u_at_idx;
    logic [15:0]       prev_end;
    logic [15:0]       a_end;
    logic              prev_adj;
    logic              next_adj;

    always_comb
    begin
        fit_found = 1'b0;
        fit_idx   = '0;
        fpos      = FIDX_W'(FREE_DEPTH);
        for (int i = FREE_DEPTH - 1; i >= 0; i--)
        begin
            if (fcell[i].valid && fcell[i].len >= item_reg.req_size)
            begin
                fit_found = 1'b1;
                fit_idx   = FIDX_W'(i);
            end
            if (!(fcell[i].valid && fcell[i].start < a_reg))
            begin
                fpos = FIDX_W'(i);
            end
        end
        rel_found = 1'b0;
        rel_idx   = '0;
        upos      = '0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--)
        begin
            if (ucell[i].valid && ucell[i].start == item_reg.req_addr)
            begin
                rel_found = 1'b1;
                rel_idx   = UIDX_W'(i);
            end
            if (!(ucell[i].valid && ucell[i].start < a_reg))
            begin
                upos = UIDX_W'(i);
            end
        end
        f_at_pos     = '0;
        f_before_pos = '0;
        f_at_idx     = '0;
        for (int i = 0; i < FREE_DEPTH; i++)
        begin
            if (FIDX_W'(i) == fpos_reg)
            begin
                f_at_pos = fcell[i];
            end
            if (FIDX_W'(i + 1) == fpos_reg)
            begin
                f_before_pos = fcell[i];
            end
            if (FIDX_W'(i) == fit_idx)
            begin
                f_at_idx = fcell[i];
            end
        end
        u_at_idx = '0;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            if (UIDX_W'(i) == rel_idx)
            begin
                u_at_idx = ucell[i];
            end
        end
        prev_end = f_before_pos.start + f_before_pos.len;
        a_end    = a_reg + len_reg;
        prev_adj = f_before_pos.valid && prev_end == a_reg;
        next_adj = f_at_pos.valid && a_end == f_at_pos.start;
    end

    // cell commands
    always_comb
    begin
        for (int i = 0; i < FREE_DEPTH; i++)
        begin
            fcmd[i] = CELL_HOLD;
        end
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            ucmd[i] = CELL_HOLD;
        end
        fload = '0;
        uload = '0;
        if (state_reg == S_IDLE && init_pend_reg)
        begin
            fload = '{valid: (mem_size_reg != 16'd0), start: '0, len: mem_size_reg};
            fcmd[0] = CELL_LOAD;
            for (int i = 1; i < FREE_DEPTH; i++)
            begin
                fcmd[i] = CELL_CLEAR;
            end
            for (int i = 0; i < MAX_BLOCKS; i++)
            begin
                ucmd[i] = CELL_CLEAR;
            end
        end
        else if (state_reg == S_CLAIM_UPD)
        begin
            fload = '{valid: 1'b1, start: a_reg + item_reg.req_size, len: len_reg};
            for (int i = 0; i < FREE_DEPTH; i++)
            begin
                if (FIDX_W'(i) == fidx_reg)
                begin
                    fcmd[i] = (len_reg == 16'd0) ? CELL_FROM_NEXT : CELL_LOAD;
                end
                else if (FIDX_W'(i) > fidx_reg && len_reg == 16'd0)
                begin
                    fcmd[i] = CELL_FROM_NEXT;
                end
            end
            uload = '{valid: 1'b1, start: a_reg, len: item_reg.req_size};
            for (int i = 0; i < MAX_BLOCKS; i++)
            begin
                if (UIDX_W'(i) == upos)
                begin
                    ucmd[i] = CELL_LOAD;
                end
                else if (UIDX_W'(i) > upos)
                begin
                    ucmd[i] = CELL_FROM_PREV;
                end
            end
        end
        else if (state_reg == S_LOOK && rel_found)
        begin
            for (int i = 0; i < MAX_BLOCKS; i++)
            begin
                if (UIDX_W'(i) >= rel_idx)
                begin
                    ucmd[i] = CELL_FROM_NEXT;
                end
            end
        end
        else if (state_reg == S_MERGE)
        begin
            if (prev_adj)
            begin
                fload = '{valid: 1'b1, start: f_before_pos.start,
                          len: prev_end - f_before_pos.start + len_reg +
                               (next_adj ? f_at_pos.len : 16'd0)};
            end
            else if (next_adj)
            begin
                fload = '{valid: 1'b1, start: a_reg, len: f_at_pos.len + len_reg};
            end
            else
            begin
                fload = '{valid: 1'b1, start: a_reg, len: len_reg};
            end
            for (int i = 0; i < FREE_DEPTH; i++)
            begin
                if (prev_adj)
                begin
                    if (FIDX_W'(i + 1) == fpos_reg)
                    begin
                        fcmd[i] = CELL_LOAD;
                    end
                    else if (next_adj && FIDX_W'(i) >= fpos_reg)
                    begin
                        fcmd[i] = CELL_FROM_NEXT;
                    end
                end
                else if (next_adj)
                begin
                    if (FIDX_W'(i) == fpos_reg)
                    begin
                        fcmd[i] = CELL_LOAD;
                    end
                end
                else if (!fv_vec[FREE_DEPTH-1])
                begin
                    if (FIDX_W'(i) == fpos_reg)
                    begin
                        fcmd[i] = CELL_LOAD;
                    end
                    else if (FIDX_W'(i) > fpos_reg)
                    begin
                        fcmd[i] = CELL_FROM_PREV;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init_pend_reg <= 1'b1;
            mem_size_reg  <= MEM_SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                mem_size_reg  <= cfg_wr_data;
                init_pend_reg <= 1'b1;
            end
            else if (state_reg == S_IDLE && init_pend_reg)
            begin
                init_pend_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        item_reg <= in_item;
                        a_reg    <= in_item.req_addr;
                        if (in_item.mode == MODE_RELEASE)
                        begin
                            state_reg <= S_LOOK;
                        end
                        else if (in_item.req_size == 16'd0)
                        begin
                            res_reg   <= '{status: ST_ZERO, block_addr: '0, block_size: '0};
                            state_reg <= S_DONE;
                        end
                        else if (uv_vec[MAX_BLOCKS-1])
                        begin
                            res_reg   <= '{status: ST_FULL, block_addr: '0, block_size: '0};
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_FIND;
                        end
                    end
                end
                S_FIND:
                begin
                    fidx_reg <= fit_idx;
                    a_reg    <= f_at_idx.start;
                    len_reg  <= f_at_idx.len - item_reg.req_size;
                    if (fit_found)
                    begin
                        state_reg <= S_CLAIM_UPD;
                    end
                    else
                    begin
                        res_reg   <= '{status: ST_NOFIT, block_addr: '0, block_size: '0};
                        state_reg <= S_DONE;
                    end
                end
                S_CLAIM_UPD:
                begin
                    res_reg   <= '{status: ST_OK, block_addr: a_reg,
                                   block_size: item_reg.req_size};
                    state_reg <= S_DONE;
                end
                S_LOOK:
                begin
                    len_reg <= u_at_idx.len;
                    if (rel_found)
                    begin
                        state_reg <= S_FPOS;
                    end
                    else
                    begin
                        res_reg   <= '{status: ST_NOTALLOC, block_addr: item_reg.req_addr,
                                       block_size: '0};
                        state_reg <= S_DONE;
                    end
                end
                S_FPOS:
                begin
                    fpos_reg  <= fpos;
                    state_reg <= S_MERGE;
                end
                S_MERGE:
                begin
                    res_reg   <= '{status: ST_OK, block_addr: a_reg, block_size: len_reg};
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = !(state_reg == S_IDLE && !init_pend_reg);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // free and used rows stay packed from entry 0
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, fv_vec} + (FREE_DEPTH + 1)'(1)))
        else $error("free table has a hole");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, uv_vec} + (MAX_BLOCKS + 1)'(1)))
        else $error("used table has a hole");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_ZERO |-> out_item.block_size == 16'd0)
        else $error("zero-size claim returned a size");

endmodule
`default_nettype wire

// File: src/ffba_cell.sv
// ffba_cell: one table entry of the allocator, shifts with its neighbors
// depends on ffba_pkg
`default_nettype none
module ffba_cell
    import ffba_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire cell_t     load_d,
    input  wire cell_t     prev_d,
    input  wire cell_t     next_d,
    output cell_t          cur
);

    logic                 valid_reg, valid_next;
    logic [ADDR_BITS-1:0] start_reg, start_next;
    logic [ADDR_BITS-1:0] len_reg, len_next;

    always_comb
    begin
        valid_next = valid_reg;
        start_next = start_reg;
        len_next   = len_reg;
        unique case (cmd)
            CELL_HOLD:
            begin
            end
            CELL_LOAD:
            begin
                valid_next = load_d.valid;
                start_next = load_d.start;
                len_next   = load_d.len;
            end
            CELL_FROM_PREV:
            begin
                valid_next = prev_d.valid;
                start_next = prev_d.start;
                len_next   = prev_d.len;
            end
            CELL_FROM_NEXT:
            begin
                valid_next = next_d.valid;
                start_next = next_d.start;
                len_next   = next_d.len;
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        len_reg   <= len_next;
    end

    assign cur = '{valid: valid_reg, start: start_reg, len: len_reg};

endmodule
`default_nettype wire
